[rtl/sac_pkg.sv]
package sac_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned TOTAL_W  = 32;

  // item opcodes
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TEXT    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAT,
    ST_ENTER,
    ST_RING,
    ST_LEAVE
  } state_e;

endpackage

[rtl/sliding_anagram_counter.sv]
// a text item's result is loaded into the output register from ST_ENTER while the window
//   fills, and from ST_LEAVE (after ST_RING) once it is full; pattern items pass through ST_PAT
// a new item is taken only once the last one is through; the count table's separate read
//   and write ports carry two read-modify-writes per full-window item
// reset, clear items and window_length writes start a clearing pass over all of the
//   2**SYMBOL_BITS count table entries (256 by default), during which items are stalled
module sliding_anagram_counter #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          window_length_we_i,
  input  logic [sac_pkg::CFG_W-1:0]     window_length_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sac_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [sac_pkg::SYMBOL_W-1:0]  symbol_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          window_full_o,
  output logic                          match_o,
  output logic [sac_pkg::TOTAL_W-1:0]   total_matches_o
);
  import sac_pkg::*;

  localparam int unsigned NSYM   = 2 ** SYMBOL_BITS;
  localparam int unsigned LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  // balance spans -MAX_WINDOW .. MAX_WINDOW
  localparam int unsigned BAL_W  = LEN_W + 1;
  // table entry: {in_pattern, balance}
  localparam int unsigned ENT_W  = BAL_W + 1;
  localparam int unsigned OUTS_W = SYMBOL_BITS + 1;

  // clamp the written length into 1..MAX_WINDOW
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > 32'(MAX_WINDOW)) begin
      w = 32'(MAX_WINDOW);
    end
    return LEN_W'(w);
  endfunction

  // ---------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [SYMBOL_BITS-1:0]  sweep_q, sweep_d;     // clearing pass address
  logic [LEN_W-1:0]        len_q, len_d;         // effective window length
  logic [LEN_W-1:0]        fill_q, fill_d;       // text bytes in window
  logic [SLOT_W-1:0]       oldest_q, oldest_d;   // ring slot of oldest byte
  logic [LEN_W-1:0]        patcnt_q, patcnt_d;   // pattern bytes loaded
  logic [OUTS_W-1:0]       outs_q, outs_d;       // symbols still outstanding
  logic [TOTAL_W-1:0]      total_q, total_d;     // saturating match total
  logic                    match_q, match_d;     // match flag held for leave step
  logic [SYMBOL_BITS-1:0]  sym_q;                // symbol of the item at work

  // ---------------------------------------------------------------------------
  // count table: one port for read and one for write, registered read data
  // ---------------------------------------------------------------------------
  logic [ENT_W-1:0]        tbl_mem [NSYM];
  logic                    tbl_we, tbl_re;
  logic [SYMBOL_BITS-1:0]  tbl_waddr, tbl_raddr;
  logic [ENT_W-1:0]        tbl_wdata;
  logic [ENT_W-1:0]        tbl_rdata_q;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // window ring: contents undefined until written
  // ---------------------------------------------------------------------------
  logic [SYMBOL_BITS-1:0]  ring_mem [MAX_WINDOW];
  logic                    ring_we, ring_re;
  logic [SLOT_W-1:0]       ring_waddr;
  logic [SYMBOL_BITS-1:0]  ring_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= symbol_i[SYMBOL_BITS-1:0];
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[oldest_q];
    end
  end

  // ring slot for the entering byte: (oldest + fill) mod len, sum stays below 2*len
  logic [LEN_W:0] wsum;
  always_comb begin
    wsum = (LEN_W+1)'(fill_q) + (LEN_W+1)'(oldest_q);
    if (wsum >= (LEN_W+1)'(len_q)) begin
      wsum = wsum - (LEN_W+1)'(len_q);
    end
    ring_waddr = SLOT_W'(wsum);
  end

  // ---------------------------------------------------------------------------
  // read-modify-write data paths
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic              out_go;
  logic              ent_present;
  logic [BAL_W-1:0]  ent_bal;
  logic [BAL_W-1:0]  bal_dec, bal_inc;
  logic [LEN_W-1:0]  fill_inc;
  logic              now_full;
  logic [OUTS_W-1:0] outs_enter;
  logic [LEN_W-1:0]  oldest_inc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  // the output register can take a result this cycle
  assign out_go      = !out_valid_o || !out_stall_i;

  assign ent_present = tbl_rdata_q[BAL_W];
  assign ent_bal     = tbl_rdata_q[BAL_W-1:0];
  assign bal_dec     = ent_bal - BAL_W'(1);
  assign bal_inc     = ent_bal + BAL_W'(1);
  assign fill_inc    = fill_q + LEN_W'(1);
  assign now_full    = (fill_inc >= len_q);
  // outstanding count once the entering byte is taken out
  assign outs_enter  = (ent_present && (bal_dec == '0)) ? outs_q - OUTS_W'(1) : outs_q;
  assign oldest_inc  = LEN_W'(oldest_q) + LEN_W'(1);

  logic emit;
  logic res_full, res_match;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    len_d     = len_q;
    fill_d    = fill_q;
    oldest_d  = oldest_q;
    patcnt_d  = patcnt_q;
    outs_d    = outs_q;
    total_d   = total_q;
    match_d   = match_q;
    tbl_we    = 1'b0;
    tbl_waddr = sym_q;
    tbl_wdata = '0;
    tbl_re    = 1'b0;
    tbl_raddr = symbol_i[SYMBOL_BITS-1:0];
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    emit      = 1'b0;
    res_full  = 1'b0;
    res_match = 1'b0;

    case (state_q)
      // zero one table entry per cycle
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = sweep_q;
        tbl_wdata = '0;
        sweep_d   = sweep_q + SYMBOL_BITS'(1);
        if (&sweep_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OP_CLEAR: begin
              state_d  = ST_CLEAR;
              sweep_d  = '0;
              fill_d   = '0;
              oldest_d = '0;
              patcnt_d = '0;
              outs_d   = '0;
              total_d  = '0;
            end
            OP_PATTERN: begin
              // surplus bytes and bytes that arrive while the fill count is nonzero are dropped
              if ((patcnt_q < len_q) && (fill_q == '0)) begin
                tbl_re  = 1'b1;
                state_d = ST_PAT;
              end
            end
            OP_TEXT: begin
              tbl_re  = 1'b1;
              ring_we = 1'b1;
              state_d = ST_ENTER;
            end
            default: begin
            end
          endcase
        end
      end

      ST_PAT: begin
        tbl_we    = 1'b1;
        tbl_wdata = {1'b1, bal_inc};
        if (!ent_present) begin
          outs_d = outs_q + OUTS_W'(1);
        end
        patcnt_d = patcnt_q + LEN_W'(1);
        state_d  = ST_IDLE;
      end

      // entering byte: lower its balance, then either report or go fetch the oldest byte
      ST_ENTER: begin
        if (now_full) begin
          tbl_we    = ent_present;
          tbl_wdata = {1'b1, bal_dec};
          outs_d    = outs_enter;
          match_d   = (outs_enter == '0);
          if ((outs_enter == '0) && !(&total_q)) begin
            total_d = total_q + TOTAL_W'(1);
          end
          ring_re = 1'b1;
          state_d = ST_RING;
        end else if (out_go) begin
          tbl_we    = ent_present;
          tbl_wdata = {1'b1, bal_dec};
          outs_d    = outs_enter;
          fill_d    = fill_inc;
          emit      = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      // oldest byte is out of the ring, look up its entry
      ST_RING: begin
        tbl_re    = 1'b1;
        tbl_raddr = ring_rdata_q;
        state_d   = ST_LEAVE;
      end

      // leaving byte: restore its balance and slide the window
      ST_LEAVE: begin
        if (out_go) begin
          tbl_we    = ent_present;
          tbl_waddr = ring_rdata_q;
          tbl_wdata = {1'b1, bal_inc};
          if (ent_present && (bal_inc == BAL_W'(1))) begin
            outs_d = outs_q + OUTS_W'(1);
          end
          oldest_d  = (oldest_inc == len_q) ? '0 : SLOT_W'(oldest_inc);
          emit      = 1'b1;
          res_full  = 1'b1;
          res_match = match_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_CLEAR;
        sweep_d = '0;
      end
    endcase

    // a length write starts a new case
    if (window_length_we_i) begin
      len_d    = eff_len(window_length_i);
      state_d  = ST_CLEAR;
      sweep_d  = '0;
      fill_d   = '0;
      oldest_d = '0;
      patcnt_d = '0;
      outs_d   = '0;
      total_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      sweep_q  <= '0;
      len_q    <= LEN_W'(1);
      fill_q   <= '0;
      oldest_q <= '0;
      patcnt_q <= '0;
      outs_q   <= '0;
      total_q  <= '0;
      match_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      len_q    <= len_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      patcnt_q <= patcnt_d;
      outs_q   <= outs_d;
      total_q  <= total_d;
      match_q  <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sym_q <= symbol_i[SYMBOL_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register: holds a finished result while the next item is taken
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic               window_full_q;
  logic               match_out_q;
  logic [TOTAL_W-1:0] total_out_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      window_full_q <= res_full;
      match_out_q   <= res_match;
      total_out_q   <= total_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign window_full_o   = window_full_q;
  assign match_o         = match_out_q;
  assign total_matches_o = total_out_q;

endmodule

[rtl/sac_checker.sv]
module sac_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          window_length_we_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [sac_pkg::OPCODE_W-1:0]  opcode_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          window_full_o,
  input logic                          match_o,
  input logic [sac_pkg::TOTAL_W-1:0]   total_matches_o
);
  import sac_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_full_o)
      && $stable(match_o) && $stable(total_matches_o))
    else $error("result changed while stalled");

  // only a full window can match
  a_match_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_o |-> window_full_o)
    else $error("match without a full window");

  // a clear item starts the table sweep
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_CLEAR) |=> in_stall_o)
    else $error("clear item not followed by sweep");

  // a length write starts the table sweep
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_length_we_i |=> in_stall_o)
    else $error("length write not followed by sweep");

  // a match result with a zero total is impossible
  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_o |-> (total_matches_o != '0))
    else $error("match reported with zero total");

endmodule

bind sliding_anagram_counter sac_checker u_sac_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import sac_pkg::*;

  // opcode 3 has no meaning in the block and must be dropped without a result
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int MAX_LEN       = 64;
  localparam int ITEM_GOAL     = 1600;
  // longer than a clearing pass plus the deepest pipeline
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 400;
  // cycles with no handshake on either side before the run is declared hung
  localparam int QUIET_LIMIT   = 5000;

  typedef struct packed {
    logic               full;
    logic               hit;
    logic [TOTAL_W-1:0] total;
  } report_t;

  // anagram window predictor plus the queue of reports it still owes
  class anagram_scoreboard;
    logic [CFG_W-1:0]   length_reg;
    int                 balance[256];
    bit                 present[256];
    logic [7:0]         ring[MAX_LEN];
    int                 outstanding;
    int                 fill;
    int                 oldest;
    int                 loaded;
    logic [TOTAL_W-1:0] total;
    report_t            pending[$];
    int                 mismatches;
    int                 reports;
    int                 full_windows;
    int                 hits;

    function new();
      length_reg   = 1;
      mismatches   = 0;
      reports      = 0;
      full_windows = 0;
      hits         = 0;
      clear_case();
    endfunction

    function void clear_case();
      foreach (balance[i]) balance[i] = 0;
      foreach (present[i]) present[i] = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      outstanding = 0;
      fill        = 0;
      oldest      = 0;
      loaded      = 0;
      total       = '0;
    endfunction

    // window size actually used: 0 acts as 1, anything above the ring depth saturates
    function int span();
      if (length_reg == 0) return 1;
      if (int'(length_reg) > MAX_LEN) return MAX_LEN;
      return int'(length_reg);
    endfunction

    function void set_length(logic [CFG_W-1:0] v);
      length_reg = v;
      clear_case();
    endfunction

    function void note_item(logic [OPCODE_W-1:0] op, logic [SYMBOL_W-1:0] sym);
      int      len;
      int      old;
      report_t r;
      len = span();
      r   = '0;
      case (op)
        OP_CLEAR: clear_case();
        OP_PATTERN: begin
          // surplus bytes and bytes that arrive while the fill count is nonzero are dropped
          if (loaded < len && fill == 0) begin
            loaded++;
            if (!present[sym]) begin
              present[sym] = 1'b1;
              outstanding++;
            end
            balance[sym]++;
          end
        end
        OP_TEXT: begin
          if (present[sym]) begin
            balance[sym]--;
            if (balance[sym] == 0) outstanding--;
          end
          ring[(oldest + fill) % len] = sym;
          fill++;
          if (fill >= len) begin
            r.full = 1'b1;
            if (outstanding == 0) begin
              r.hit = 1'b1;
              if (total != '1) total++;
            end
            old = ring[oldest % len];
            if (present[old]) begin
              balance[old]++;
              if (balance[old] == 1) outstanding++;
            end
            oldest = (oldest + 1) % len;
            fill--;
          end
          r.total = total;
          pending = {pending, r};
        end
        default: ;
      endcase
    endfunction

    function void check_report(logic full, logic hit, logic [TOTAL_W-1:0] tot);
      report_t want;
      if (pending.size() == 0) begin
        $display("%0t: report with none pending: full %0b match %0b total %0d",
                 $time, full, hit, tot);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      reports++;
      if (want.full) full_windows++;
      if (want.hit) hits++;
      if (full !== want.full) begin
        $display("%0t: window_full expected %0b actual %0b", $time, want.full, full);
        mismatches++;
      end
      if (hit !== want.hit) begin
        $display("%0t: match expected %0b actual %0b", $time, want.hit, hit);
        mismatches++;
      end
      if (tot !== want.total) begin
        $display("%0t: total_matches expected %0d actual %0d", $time, want.total, tot);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                window_length_we_i;
  logic [CFG_W-1:0]    window_length_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OPCODE_W-1:0] opcode_i;
  logic [SYMBOL_W-1:0] symbol_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                window_full_o;
  logic                match_o;
  logic [TOTAL_W-1:0]  total_matches_o;

  anagram_scoreboard sb;

  // idle percentages of the current phase, shared with the result side
  int send_idle_pct;
  int recv_stall_pct;
  // each bump asks the result side for one long hold-off
  int hold_requests;
  int items_sent;

  sliding_anagram_counter dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .window_length_we_i (window_length_we_i),
    .window_length_i    (window_length_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .symbol_i           (symbol_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .window_full_o      (window_full_o),
    .match_o            (match_o),
    .total_matches_o    (total_matches_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // offer one item, with a random gap first, and return at the edge that takes it;
  // the caller drives the next item or drops valid in that same step
  task automatic drive_item(input logic [OPCODE_W-1:0] op, input logic [SYMBOL_W-1:0] sym);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    symbol_i   <= sym;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(op, sym);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // drain every owed report, then let a clear or pattern item still in flight finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    settle();
    window_length_we_i <= 1'b1;
    window_length_i    <= v;
    @(posedge clk_i);
    window_length_we_i <= 1'b0;
    sb.set_length(v);
  endtask

  // one case: clear (unless skipped), pattern, then text built from shuffled copies of the pattern
  // and filler from the same small alphabet, with some noise mixed in
  task automatic run_case(input bit skip_clear, input bit squeeze);
    int         len;
    int         k;
    int         npat;
    int         ntext;
    int         j;
    int         pick;
    int         roll;
    logic [7:0] tmp;
    logic [7:0] sym;
    logic [7:0] alph[4];
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    logic [7:0] perm[$];
    len = sb.span();
    if (!skip_clear) drive_item(OP_CLEAR, SYMBOL_W'($urandom_range(0, 255)));
    k = $urandom_range(1, 4);
    foreach (alph[i]) alph[i] = 8'($urandom_range(0, 255));
    // mostly a complete pattern, sometimes a short one (even empty) or surplus bytes
    pick = $urandom_range(0, 9);
    if (pick < 8) npat = len;
    else if (pick == 8) npat = $urandom_range(0, len - 1);
    else npat = len + $urandom_range(1, 3);
    for (j = 0; j < npat; j++) pat = {pat, alph[$urandom_range(0, k - 1)]};
    foreach (pat[i]) begin
      if ($urandom_range(0, 29) == 0) drive_item(OP_UNUSED, SYMBOL_W'($urandom_range(0, 255)));
      drive_item(OP_PATTERN, pat[i]);
    end
    ntext = len + $urandom_range(4, len + 12);
    while (txt.size() < ntext) begin
      if ($urandom_range(0, 2) == 0 && pat.size() > 0) begin
        perm.delete();
        for (j = 0; j < pat.size() && j < len; j++) perm = {perm, pat[j]};
        for (j = perm.size() - 1; j > 0; j--) begin
          pick    = $urandom_range(0, j);
          tmp     = perm[j];
          perm[j] = perm[pick];
          perm[pick] = tmp;
        end
        foreach (perm[i]) txt = {txt, perm[i]};
      end else begin
        txt = {txt, alph[$urandom_range(0, k - 1)]};
      end
    end
    // long receiver hold-off while text keeps coming, so the block backs up
    if (squeeze) hold_requests <= hold_requests + 1;
    foreach (txt[i]) begin
      sym  = txt[i];
      roll = $urandom_range(0, 59);
      if (roll == 0) drive_item(OP_UNUSED, SYMBOL_W'($urandom_range(0, 255)));
      if (roll == 1) drive_item(OP_PATTERN, SYMBOL_W'($urandom_range(0, 255)));
      if (roll == 2) sym = 8'($urandom_range(0, 255));
      if (roll == 3) drive_item(OP_CLEAR, SYMBOL_W'($urandom_range(0, 255)));
      drive_item(OP_TEXT, sym);
    end
  endtask

  // sender side and overall sequencing
  initial begin
    int               phase;
    int               ncase;
    int               mode;
    logic [CFG_W-1:0] nl;
    rst_ni             = 1'b0;
    window_length_we_i = 1'b0;
    window_length_i    = '0;
    in_valid_i         = 1'b0;
    opcode_i           = OP_CLEAR;
    symbol_i           = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_requests      = 0;
    items_sent         = 0;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at the reset length of one
    drive_item(OP_TEXT, 8'hFF);         // no pattern: every full window matches
    drive_item(OP_UNUSED, 8'hAA);       // ignored opcode
    drive_item(OP_PATTERN, 8'h00);      // window drained at length one, still taken
    drive_item(OP_TEXT, 8'h00);
    drive_item(OP_CLEAR, 8'hFF);
    drive_item(OP_PATTERN, 8'h00);
    drive_item(OP_PATTERN, 8'h55);      // surplus pattern byte
    drive_item(OP_TEXT, 8'h00);
    drive_item(OP_TEXT, 8'hFF);
    drive_item(OP_TEXT, 8'h55);
    drive_item(OP_TEXT, 8'h00);
    drive_item(OP_CLEAR, 8'h00);

    // directed, length three: fill-up, repeated symbols, late and short patterns
    write_length(7'd3);
    drive_item(OP_PATTERN, 8'h80);
    drive_item(OP_PATTERN, 8'h01);
    drive_item(OP_PATTERN, 8'h80);
    drive_item(OP_TEXT, 8'h01);         // window not full yet
    drive_item(OP_PATTERN, 8'h7F);      // late pattern byte
    drive_item(OP_TEXT, 8'h80);
    drive_item(OP_TEXT, 8'h80);
    drive_item(OP_TEXT, 8'h01);
    drive_item(OP_TEXT, 8'h7F);
    drive_item(OP_CLEAR, 8'h00);
    drive_item(OP_PATTERN, 8'h01);      // incomplete pattern
    drive_item(OP_TEXT, 8'h01);
    drive_item(OP_TEXT, 8'h02);
    drive_item(OP_TEXT, 8'h03);

    // random phases: the length extremes first, then mostly short windows
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      mode = phase % 4;
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case (phase)
        0: nl = 7'd0;
        1: nl = 7'd127;
        2: nl = 7'd64;
        3: nl = 7'd1;
        4: nl = 7'd2;
        default: begin
          if ($urandom_range(0, 5) == 0) nl = CFG_W'($urandom_range(9, 127));
          else nl = CFG_W'($urandom_range(1, 8));
        end
      endcase
      write_length(nl);
      ncase = (sb.span() > 16) ? 1 : $urandom_range(2, 5);
      for (int c = 0; c < ncase; c++) begin
        run_case(c == 0 && $urandom_range(0, 1) == 1, phase == 3 && c == 0);
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d items over %0d window settings, lengths 0 to 127 and back", items_sent,
             phase + 2);
    $display("%0d text reports checked, %0d with a full window, %0d anagram hits",
             sb.reports, sb.full_windows, sb.hits);
    if (sb.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // result side: check each taken report, then pick the stall for the next edge
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_report(window_full_o, match_o, total_matches_o);
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // hang detector: any handshake on either side restarts the count
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("testbench failed");
    $finish;
  end

endmodule
